@@ sv/periodic_task_timer_table_defines.svh @@
// Assertion macros used by the checker file ptt_checker.sv.
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define PTT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/ptt_pkg.sv @@
// ---------------------------------------------------------------------------
// ptt_pkg
// Shared constants and types of the periodic task timer table.
// ---------------------------------------------------------------------------
package ptt_pkg;
    localparam int TableSizeDef = 8;
    localparam int IdWidthDef = 8;
    localparam int CountWidthDef = 32;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED = 3'd0,
        ST_ADDED = 3'd1,
        ST_FULL = 3'd2,
        ST_DELETED = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_TICKED = 3'd5,
        ST_DUE = 3'd6,
        ST_NONE_DUE = 3'd7
    } status_t;

    typedef struct packed {
        op_t operation;
        logic [15:0] task_id;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
    } cmd_t;
endpackage

@@ sv/ptt_front.sv @@
// ---------------------------------------------------------------------------
// ptt_front
// Command front end: takes command beats and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module ptt_front
    import ptt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t head
);
    cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg;
    logic wr_reg;

    assign full = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign head = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/ptt_back.sv @@
// ---------------------------------------------------------------------------
// ptt_back
// Task table and the sequencer that walks it one entry per cycle.
// ---------------------------------------------------------------------------
module ptt_back
    import ptt_pkg::*;
#(
    parameter int TABLE_SIZE = TableSizeDef,
    parameter int ID_WIDTH = IdWidthDef,
    parameter int COUNT_WIDTH = CountWidthDef
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic avail,
    input  cmd_t cmd,
    output logic take,
    output logic strobe,
    output logic [7:0] due_task,
    output logic [2:0] status,
    output logic removed_one_shot,
    output logic last
);
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    logic [ID_WIDTH-1:0] ids_reg [TABLE_SIZE];
    logic [COUNT_WIDTH-1:0] dly_reg [TABLE_SIZE];
    logic [COUNT_WIDTH-1:0] per_reg [TABLE_SIZE];
    logic rdy_reg [TABLE_SIZE];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    state_t state_reg;
    op_t op_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [COUNT_WIDTH-1:0] sd_reg;
    logic [COUNT_WIDTH-1:0] rp_reg;
    logic any_reg;
    logic [7:0] pend_id_reg;
    logic pend_rm_reg;
    logic hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] ix;
    logic [IW-1:0] lx;
    logic at_end;
    logic [ID_WIDTH-1:0] id_ext;

    assign ix = idx_reg[IW-1:0];
    assign lx = IW'(cnt_reg - CW'(1));
    assign at_end = (idx_reg >= cnt_reg);
    assign take = (state_reg == S_IDLE) && avail;

    always_comb
    begin
        id_ext = ids_reg[ix];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= cmd.operation;
            id_reg <= cmd.task_id[ID_WIDTH-1:0];
            sd_reg <= cmd.start_delay[COUNT_WIDTH-1:0];
            rp_reg <= cmd.repeat_period[COUNT_WIDTH-1:0];
        end
        if (state_reg == S_WALK && !at_end)
        begin
            unique case (op_reg)
                OP_TICK:
                begin
                    if (dly_reg[ix] != '0)
                    begin
                        dly_reg[ix] <= dly_reg[ix] - COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        rdy_reg[ix] <= 1'b1;
                    end
                end
                OP_DISPATCH:
                begin
                    if (rdy_reg[ix])
                    begin
                        if (per_reg[ix] == '0)
                        begin
                            ids_reg[ix] <= ids_reg[lx];
                            dly_reg[ix] <= dly_reg[lx];
                            per_reg[ix] <= per_reg[lx];
                            rdy_reg[ix] <= rdy_reg[lx];
                        end
                        else
                        begin
                            rdy_reg[ix] <= 1'b0;
                            if (dly_reg[ix] == '0)
                            begin
                                dly_reg[ix] <= per_reg[ix] - COUNT_WIDTH'(1);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_DONE)
        begin
            if (op_reg == OP_SET)
            begin
                if (hit_reg)
                begin
                    dly_reg[hit_idx_reg] <= sd_reg;
                    per_reg[hit_idx_reg] <= rp_reg;
                    rdy_reg[hit_idx_reg] <= 1'b0;
                end
                else if (cnt_reg < CW'(TABLE_SIZE))
                begin
                    ids_reg[lx + IW'(1)] <= id_reg;
                    dly_reg[lx + IW'(1)] <= sd_reg;
                    per_reg[lx + IW'(1)] <= rp_reg;
                    rdy_reg[lx + IW'(1)] <= 1'b0;
                end
            end
            else if (op_reg == OP_DELETE && hit_reg)
            begin
                ids_reg[hit_idx_reg] <= ids_reg[lx];
                dly_reg[hit_idx_reg] <= dly_reg[lx];
                per_reg[hit_idx_reg] <= per_reg[lx];
                rdy_reg[hit_idx_reg] <= rdy_reg[lx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            any_reg <= 1'b0;
            pend_id_reg <= '0;
            pend_rm_reg <= 1'b0;
            hit_reg <= 1'b0;
            hit_idx_reg <= '0;
            strobe <= 1'b0;
            due_task <= '0;
            status <= ST_UPDATED;
            removed_one_shot <= 1'b0;
            last <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            removed_one_shot <= 1'b0;
            last <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    any_reg <= 1'b0;
                    hit_reg <= 1'b0;
                    if (take)
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (at_end)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_DISPATCH:
                            begin
                                if (rdy_reg[ix])
                                begin
                                    // Each due beat is held back until the next
                                    // one is found, so the final one can carry last.
                                    strobe <= any_reg;
                                    due_task <= pend_id_reg;
                                    status <= ST_DUE;
                                    removed_one_shot <= pend_rm_reg;
                                    any_reg <= 1'b1;
                                    pend_id_reg <= 8'(id_ext);
                                    pend_rm_reg <= (per_reg[ix] == '0);
                                    if (per_reg[ix] == '0)
                                    begin
                                        cnt_reg <= cnt_reg - CW'(1);
                                    end
                                end
                                idx_reg <= idx_reg + CW'(1);
                            end
                            OP_TICK:
                            begin
                                idx_reg <= idx_reg + CW'(1);
                            end
                            default:
                            begin
                                if (!hit_reg && ids_reg[ix] == id_reg)
                                begin
                                    hit_reg <= 1'b1;
                                    hit_idx_reg <= ix;
                                end
                                idx_reg <= idx_reg + CW'(1);
                            end
                        endcase
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    strobe <= 1'b1;
                    last <= 1'b1;
                    due_task <= 8'(id_reg);
                    unique case (op_reg)
                        OP_SET:
                        begin
                            if (hit_reg)
                            begin
                                status <= ST_UPDATED;
                            end
                            else if (cnt_reg < CW'(TABLE_SIZE))
                            begin
                                status <= ST_ADDED;
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            else
                            begin
                                status <= ST_FULL;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (hit_reg)
                            begin
                                status <= ST_DELETED;
                                cnt_reg <= cnt_reg - CW'(1);
                            end
                            else
                            begin
                                status <= ST_NOT_FOUND;
                            end
                        end
                        OP_TICK:
                        begin
                            status <= ST_TICKED;
                            due_task <= '0;
                        end
                        default:
                        begin
                            // Dispatch ends with the held due beat, or with a
                            // none-due beat when no task was ready.
                            if (any_reg)
                            begin
                                status <= ST_DUE;
                                due_task <= pend_id_reg;
                                removed_one_shot <= pend_rm_reg;
                            end
                            else
                            begin
                                status <= ST_NONE_DUE;
                                due_task <= '0;
                            end
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/periodic_task_timer_table.sv @@
// ---------------------------------------------------------------------------
// periodic_task_timer_table
// Packed task table with set, delete, tick and dispatch commands.
// ---------------------------------------------------------------------------
// Each command walks the live entries one per cycle in the back end, which
// stays occupied until the walk and its done state are over; a
// two-entry queue ahead of it takes commands while busy is low. Results
// leave as one-cycle strobed beats and cannot be stalled.
module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int TABLE_SIZE = TableSizeDef,
    parameter int ID_WIDTH = IdWidthDef,
    parameter int COUNT_WIDTH = CountWidthDef
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] operation,
    input  logic [7:0] task_id,
    input  logic [31:0] start_delay,
    input  logic [31:0] repeat_period,
    output logic strobe,
    output logic [7:0] due_task,
    output logic [2:0] status,
    output logic removed_one_shot,
    output logic last
);
    cmd_t in_cmd;
    cmd_t head;
    logic push;
    logic full;
    logic nonempty;
    logic take;

    assign in_cmd.operation = op_t'(operation);
    assign in_cmd.task_id = 16'(task_id);
    assign in_cmd.start_delay = start_delay;
    assign in_cmd.repeat_period = repeat_period;
    assign push = start && !busy;
    assign busy = full;

    ptt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(in_cmd), .full(full),
        .pop(take), .nonempty(nonempty), .head(head)
    );

    ptt_back #(
        .TABLE_SIZE(TABLE_SIZE), .ID_WIDTH(ID_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .avail(nonempty), .cmd(head), .take(take),
        .strobe(strobe), .due_task(due_task), .status(status),
        .removed_one_shot(removed_one_shot), .last(last)
    );
endmodule

@@ sv/ptt_checker.sv @@
// ---------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the periodic task timer table.
// ---------------------------------------------------------------------------
`include "periodic_task_timer_table_defines.svh"
module ptt_checker
    import ptt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic strobe,
    input logic [2:0] status,
    input logic removed_one_shot,
    input logic last
);
    `PTT_ASSERT_IMPL(a_rm_due, strobe && removed_one_shot, status == ST_DUE)
    `PTT_ASSERT_IMPL(a_none_last, strobe && status == ST_NONE_DUE, last)
    `PTT_ASSERT_IMPL(a_last_strobe, last, strobe)
    `PTT_ASSERT_NEXT(a_gap, strobe && last, !strobe)
endmodule

bind periodic_task_timer_table ptt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .strobe(strobe), .status(status),
    .removed_one_shot(removed_one_shot), .last(last)
);

@@ dv/periodic_task_timer_table_tb.sv @@
// ---------------------------------------------------------------------------
// periodic_task_timer_table_tb
// Self-checking testbench for the periodic task timer table. Commands are
// queued by an initial block and issued in random bursts by a clocked
// driver; a shadow task table predicts every result beat, and a clocked
// monitor compares each strobed beat with the oldest prediction.
// ---------------------------------------------------------------------------
module periodic_task_timer_table_tb;
    import ptt_pkg::*;

    localparam int Slots = 8;

    typedef struct {
        logic [1:0]  operation;
        logic [7:0]  task_id;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
    } cmd_item_t;

    typedef struct {
        logic [7:0] due_task;
        logic [2:0] status;
        logic       removed_one_shot;
        logic       last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [7:0]  task_id;
    logic [31:0] start_delay;
    logic [31:0] repeat_period;
    logic        strobe;
    logic [7:0]  due_task;
    logic [2:0]  status;
    logic        removed_one_shot;
    logic        last;

    cmd_item_t   pending_cmds[$];
    beat_t       expected_beats[$];
    int          error_count = 0;
    int          beats_seen = 0;
    int          cmds_issued = 0;
    int          dispatch_hits = 0;
    bit          hold_off;
    int          burst_left;
    int          gap_left;

    int          shadow_count = 0;
    logic [7:0]  shadow_id[Slots];
    logic [31:0] shadow_delay[Slots];
    logic [31:0] shadow_period[Slots];
    logic        shadow_ready[Slots];

    periodic_task_timer_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .task_id(task_id),
        .start_delay(start_delay),
        .repeat_period(repeat_period),
        .strobe(strobe),
        .due_task(due_task),
        .status(status),
        .removed_one_shot(removed_one_shot),
        .last(last)
    );

    always #1 clk = ~clk;

    task automatic push_beat(input logic [7:0] id, input status_t st, input logic rm);
        beat_t b;
        b.due_task = id;
        b.status = st;
        b.removed_one_shot = rm;
        b.last = 1'b0;
        expected_beats.push_back(b);
    endtask

    task automatic drop_slot(input int idx);
        int t;
        t = shadow_count - 1;
        if (idx != t)
        begin
            shadow_id[idx] = shadow_id[t];
            shadow_delay[idx] = shadow_delay[t];
            shadow_period[idx] = shadow_period[t];
            shadow_ready[idx] = shadow_ready[t];
        end
        shadow_count = t;
    endtask

    task automatic predict_table(input cmd_item_t c);
        int found;
        int n;
        logic [7:0] tid;
        found = -1;
        n = 0;
        for (int i = 0; i < shadow_count; i++)
            if (found < 0 && shadow_id[i] == c.task_id)
                found = i;
        case (op_t'(c.operation))
            OP_SET:
            begin
                if (found >= 0)
                begin
                    shadow_delay[found] = c.start_delay;
                    shadow_period[found] = c.repeat_period;
                    shadow_ready[found] = 1'b0;
                    push_beat(c.task_id, ST_UPDATED, 1'b0);
                end
                else if (shadow_count < Slots)
                begin
                    shadow_id[shadow_count] = c.task_id;
                    shadow_delay[shadow_count] = c.start_delay;
                    shadow_period[shadow_count] = c.repeat_period;
                    shadow_ready[shadow_count] = 1'b0;
                    shadow_count++;
                    push_beat(c.task_id, ST_ADDED, 1'b0);
                end
                else
                    push_beat(c.task_id, ST_FULL, 1'b0);
                n = 1;
            end
            OP_DELETE:
            begin
                if (found >= 0)
                begin
                    drop_slot(found);
                    push_beat(c.task_id, ST_DELETED, 1'b0);
                end
                else
                    push_beat(c.task_id, ST_NOT_FOUND, 1'b0);
                n = 1;
            end
            OP_TICK:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_delay[i] != 0)
                        shadow_delay[i] = shadow_delay[i] - 1;
                    else
                        shadow_ready[i] = 1'b1;
                push_beat(8'd0, ST_TICKED, 1'b0);
                n = 1;
            end
            default:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_ready[i])
                    begin
                        if (shadow_period[i] == 0)
                        begin
                            tid = shadow_id[i];
                            drop_slot(i);
                            push_beat(tid, ST_DUE, 1'b1);
                        end
                        else
                        begin
                            shadow_ready[i] = 1'b0;
                            if (shadow_delay[i] == 0)
                                shadow_delay[i] = shadow_period[i] - 1;
                            push_beat(shadow_id[i], ST_DUE, 1'b0);
                        end
                        n++;
                        dispatch_hits++;
                    end
                end
                if (n == 0)
                begin
                    push_beat(8'd0, ST_NONE_DUE, 1'b0);
                    n = 1;
                end
            end
        endcase
        expected_beats[$].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at beat %0d: %s got %0h expected %0h", beats_seen, what, got, want);
        error_count++;
    endtask

    task automatic queue_cmd(input op_t op, input logic [7:0] id, input logic [31:0] dly,
                             input logic [31:0] per);
        cmd_item_t c;
        c.operation = op;
        c.task_id = id;
        c.start_delay = dly;
        c.repeat_period = per;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [31:0] small_count();
        case ($urandom_range(0, 9))
            0: small_count = $urandom;
            1: small_count = 32'hFFFF_FFFF;
            2: small_count = 32'd0;
            default: small_count = $urandom_range(0, 4);
        endcase
    endfunction

    // Driver: issues one command per accepted beat, in bursts with gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            operation <= '0;
            task_id <= '0;
            start_delay <= '0;
            repeat_period <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_table('{operation, task_id, start_delay, repeat_period});
                cmds_issued++;
            end
            if (start && busy)
            begin
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() == 0 || (hold_off && expected_beats.size() != 0))
                start <= 1'b0;
            else
            begin
                operation <= pending_cmds[0].operation;
                task_id <= pending_cmds[0].task_id;
                start_delay <= pending_cmds[0].start_delay;
                repeat_period <= pending_cmds[0].repeat_period;
                void'(pending_cmds.pop_front());
                start <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: every strobed beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", {24'd0, due_task}, 32'd0);
            end
            else
            begin
                if (due_task !== expected_beats[0].due_task)
                    report_mismatch("due_task", 32'(due_task),
                                    32'(expected_beats[0].due_task));
                if (status !== expected_beats[0].status)
                    report_mismatch("status", 32'(status), 32'(expected_beats[0].status));
                if (removed_one_shot !== expected_beats[0].removed_one_shot)
                    report_mismatch("removed_one_shot", 32'(removed_one_shot),
                                    32'(expected_beats[0].removed_one_shot));
                if (last !== expected_beats[0].last)
                    report_mismatch("last", 32'(last), 32'(expected_beats[0].last));
                void'(expected_beats.pop_front());
            end
            beats_seen++;
        end
    end

    initial
    begin
        #400000;
        $display("periodic_task_timer_table_tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [7:0] ids[6];
        int r;
        clk = 1'b0;
        rst_n = 1'b0;
        hold_off = 1'b0;

        queue_cmd(OP_DISPATCH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_DELETE, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_TICK, 8'hAA, 32'd5, 32'd5);
        queue_cmd(OP_SET, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_SET, 8'hFF, 32'd1, 32'd3);
        queue_cmd(OP_SET, 8'h55, 32'd0, 32'hFFFF_FFFF);
        queue_cmd(OP_SET, 8'hAA, 32'hFFFF_FFFF, 32'd1);
        queue_cmd(OP_SET, 8'h01, 32'd0, 32'd0);
        queue_cmd(OP_SET, 8'h02, 32'd1, 32'd0);
        queue_cmd(OP_SET, 8'h03, 32'd0, 32'd2);
        queue_cmd(OP_SET, 8'h04, 32'd0, 32'd0);
        queue_cmd(OP_SET, 8'h05, 32'd0, 32'd0);
        queue_cmd(OP_SET, 8'h55, 32'd0, 32'd1);
        queue_cmd(OP_TICK, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_TICK, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_DISPATCH, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_DISPATCH, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_DELETE, 8'hFF, 32'd0, 32'd0);
        queue_cmd(OP_DELETE, 8'hFF, 32'd0, 32'd0);
        queue_cmd(OP_TICK, 8'h00, 32'd0, 32'd0);
        queue_cmd(OP_DISPATCH, 8'h00, 32'd0, 32'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0);
        hold_off = 1'b1;
        for (int k = 0; k < 6; k++)
            ids[k] = 8'($urandom);
        for (int k = 0; k < 260; k++)
        begin
            r = $urandom_range(0, 99);
            if (k == 130)
                hold_off = 1'b1;
            if (k == 140)
                hold_off = 1'b0;
            if (r < 30)
                queue_cmd(OP_SET, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                          : ids[$urandom_range(0, 5)], small_count(),
                          ($urandom_range(0, 2) == 0) ? 32'd0 : small_count());
            else if (r < 40)
                queue_cmd(OP_DELETE, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                          : ids[$urandom_range(0, 5)], $urandom, $urandom);
            else if (r < 75)
                queue_cmd(OP_TICK, 8'($urandom), $urandom, $urandom);
            else
                queue_cmd(OP_DISPATCH, 8'($urandom), $urandom, $urandom);
            if (k == 20)
            begin
                wait (pending_cmds.size() == 0);
                hold_off = 1'b0;
            end
        end

        wait (pending_cmds.size() == 0 && !start && expected_beats.size() == 0);
        repeat (40) @(posedge clk);
        $display("issued %0d commands, checked %0d result beats, %0d tasks dispatched",
                 cmds_issued, beats_seen, dispatch_hits);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("periodic_task_timer_table_tb OK");
        else
            $display("periodic_task_timer_table_tb NOT OK");
        $finish;
    end
endmodule
